### src/chs_pkg.sv
// Package for the chained hash set: sizes, link encoding, operation codes
// and the queue item type shared by the front and back parts.
// No dependencies.
package chs_pkg;

  localparam int KEY_W   = 32;
  // BUCKETS must be a power of two: the bucket is the low bits of the key.
  localparam int BUCKETS = 1024;
  localparam int NODES   = 1024;
  localparam int QDEPTH  = 2;

  localparam int BKT_AW  = $clog2(BUCKETS);
  localparam int NODE_AW = $clog2(NODES);
  localparam int LINK_W  = $clog2(NODES + 1);
  localparam int Q_AW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(NODES);
  localparam logic [BKT_AW-1:0] BKT_LAST   = BKT_AW'(BUCKETS - 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic [BKT_AW-1:0]       bucket;
  } item_t;

endpackage

### src/chs_if.sv
// Channel interfaces of the chained hash set: request words and result words.
// Depends on chs_pkg for the key width.
interface chs_in_if;
  import chs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [KEY_W-1:0] key;
  modport source (output valid, output func, output key, input ready);
  modport sink (input valid, input func, input key, output ready);
endinterface

interface chs_out_if;
  logic valid;
  logic ready;
  logic found;
  logic status;
  modport source (output valid, output found, output status, input ready);
  modport sink (input valid, input found, input status, output ready);
endinterface

### src/chs_front.sv
// Front part: accepts request words, decodes the operation and bucket, and
// holds them in a short queue for the back part. Depends on chs_pkg, chs_if.
module chs_front import chs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  chs_in_if.sink   in_ch,
  input  logic     busy,
  output logic     q_valid,
  output item_t    q_item,
  input  logic     q_pop
);

  item_t             q_mem [QDEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  item_t             new_item;

  assign in_ch.ready = (count_r != QCNT_W'(QDEPTH)) && !busy;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    new_item.op     = op_t'(in_ch.func);
    new_item.key    = in_ch.key;
    new_item.bucket = in_ch.key[BKT_AW-1:0];
  end

  assign q_valid = (count_r != '0);
  assign q_item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

### src/chs_back.sv
// Back part: owns the bucket head, node key and node link memories, clears
// the heads after reset, performs inserts and chain walks, and holds the
// result word. Depends on chs_pkg and chs_if.
module chs_back import chs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  item_t    q_item,
  output logic     q_pop,
  output logic     busy,
  chs_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HEAD  = 5'b00100,
    S_WALK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [BKT_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LINK_W-1:0] used_r, used_nxt;
  item_t             item_r, item_nxt;
  logic              res_found_r, res_found_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_status_r;
  logic              out_load;

  logic [LINK_W-1:0] head_mem [BUCKETS];
  logic              head_we;
  logic [BKT_AW-1:0] head_wa;
  logic [LINK_W-1:0] head_wd;
  logic [LINK_W-1:0] head_rd_r;

  logic [KEY_W-1:0]   key_mem [NODES];
  logic [LINK_W-1:0]  next_mem [NODES];
  logic               node_we;
  logic [NODE_AW-1:0] node_wa;
  logic [NODE_AW-1:0] node_ra;
  logic [KEY_W-1:0]   key_rd_r;
  logic [LINK_W-1:0]  next_rd_r;

  assign busy          = (state_r == S_CLEAR);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    used_nxt       = used_r;
    item_nxt       = item_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    head_we        = 1'b0;
    head_wa        = item_r.bucket;
    head_wd        = used_r;
    node_we        = 1'b0;
    node_wa        = used_r[NODE_AW-1:0];
    node_ra        = '0;
    unique case (state_r)
      S_CLEAR: begin
        head_we     = 1'b1;
        head_wa     = clr_cnt_r;
        head_wd     = EMPTY_LINK;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BKT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        res_found_nxt  = 1'b0;
        res_status_nxt = ST_DONE;
        state_nxt      = S_RESP;
        if (item_r.op == OP_INSERT) begin
          if (used_r == EMPTY_LINK) begin
            res_status_nxt = ST_FULL;
          end else begin
            head_we  = 1'b1;
            node_we  = 1'b1;
            used_nxt = used_r + 1'b1;
          end
        end else if (head_rd_r != EMPTY_LINK) begin
          node_ra   = head_rd_r[NODE_AW-1:0];
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (key_rd_r == item_r.key) begin
          res_found_nxt = 1'b1;
          state_nxt     = S_RESP;
        end else if (next_rd_r == EMPTY_LINK) begin
          state_nxt = S_RESP;
        end else begin
          node_ra = next_rd_r[NODE_AW-1:0];
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_r <= head_mem[q_item.bucket];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      key_mem[node_wa]  <= item_r.key;
      next_mem[node_wa] <= head_rd_r;
    end
    key_rd_r  <= key_mem[node_ra];
    next_rd_r <= next_mem[node_ra];
  end

endmodule

### src/chained_hash_set.sv
// Top level of the chained hash set: a set of signed 32-bit keys kept as a
// hash table with separate chaining in on-chip memories.
// Depends on chs_pkg, chs_if, chs_front and chs_back.
//
// The request channel carries func (0 insert, 1 query) and key; every request
// word yields exactly one result word with found and status (1 when an insert
// is refused because the node store is full). Results come back in order.
// The bucket is the key modulo the bucket count, taken from its low bits.
// After reset the back part clears every bucket head, one per cycle, and no
// request word is accepted during that pass. Requests enter a two-entry
// queue, so up to two words are taken while the back part is working. The
// back part handles one word at a time: it takes a word from the queue, reads
// the bucket head, links in a new node for an insert or walks the chain node
// by node through the single read port of the node memories for a query, and
// loads the result register. The result register holds a word until the
// receiver takes it; while it is stalled the next item is still carried out
// and waits in the back part, and the queue keeps accepting until it fills.
module chained_hash_set import chs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  chs_in_if.sink    in_ch,
  chs_out_if.source out_ch
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;
  logic  busy;

  chs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  chs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .busy    (busy),
    .out_ch  (out_ch)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("request accepted during head clearing");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_ch.valid)
    else $error("result presented during head clearing");

endmodule

### tb/sv/tb_chained_hash_set.sv
// Self-checking testbench for chained_hash_set: a directed table, random inserts and queries
// under three handshake idling phases, a fill to a full node store, all checked in order.
// Depends on chs_pkg, chs_if and the chained_hash_set RTL.
module tb_chained_hash_set;
  import chs_pkg::*;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic                    found;
    logic                    status;
  } answer_t;

  typedef struct packed {
    logic                    after_fill;
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic                    pinned;
    logic                    found;
    logic                    status;
  } script_row_t;

  localparam int SCRIPT_LEN = 23;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, OP_QUERY,  32'sd0,            1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_QUERY,  32'sh8000_0000,    1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, 32'sh8000_0000,    1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, 32'sh7fff_ffff,    1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, 32'sd0,            1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, -32'sd1,           1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, -32'sd1,           1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, -32'sd1024,        1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_QUERY,  32'sh8000_0000,    1'b1, 1'b1, ST_DONE},
    '{1'b0, OP_QUERY,  32'sd0,            1'b1, 1'b1, ST_DONE},
    '{1'b0, OP_QUERY,  32'sd1024,         1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_QUERY,  32'sh7fff_ffff,    1'b1, 1'b1, ST_DONE},
    '{1'b0, OP_QUERY,  -32'sd1,           1'b1, 1'b1, ST_DONE},
    '{1'b0, OP_QUERY,  32'sd1023,         1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_QUERY,  32'sd1,            1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_INSERT, 32'sd1,            1'b1, 1'b0, ST_DONE},
    '{1'b0, OP_QUERY,  32'sd1,            1'b1, 1'b1, ST_DONE},
    '{1'b0, OP_QUERY,  -32'sd1023,        1'b1, 1'b0, ST_DONE},
    '{1'b1, OP_INSERT, 32'sd5,            1'b1, 1'b0, ST_FULL},
    '{1'b1, OP_INSERT, 32'sh8000_0000,    1'b1, 1'b0, ST_FULL},
    '{1'b1, OP_QUERY,  32'sh7fff_ffff,    1'b1, 1'b1, ST_DONE},
    '{1'b1, OP_QUERY,  32'sd5,            1'b0, 1'b0, ST_DONE},
    '{1'b1, OP_QUERY,  32'sd1,            1'b1, 1'b1, ST_DONE}
  };

  logic clk;
  logic rst_n;

  chs_in_if  in_ch ();
  chs_out_if out_ch ();

  chained_hash_set dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [LINK_W-1:0]       shadow_head [BUCKETS];
  logic signed [KEY_W-1:0] shadow_key  [NODES];
  logic [LINK_W-1:0]       shadow_next [NODES];
  int                      shadow_used;

  logic signed [KEY_W-1:0] stored_keys [$];
  answer_t                 expected_answers [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int inserts_taken;
  int inserts_refused;
  int query_hits;
  int query_misses;

  always #10 clk = ~clk;

  task automatic log_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int bucket_of_key(logic signed [KEY_W-1:0] k);
    int r;
    r = k % BUCKETS;
    if (r < 0) begin
      r += BUCKETS;
    end
    return r;
  endfunction

  function automatic answer_t hash_set_apply(op_t op, logic signed [KEY_W-1:0] k);
    answer_t     ans;
    int          b;
    int          steps;
    logic [LINK_W-1:0] cur;
    b = bucket_of_key(k);
    ans.op = op;
    ans.key = k;
    ans.found = 1'b0;
    ans.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (shadow_used >= NODES) begin
        ans.status = ST_FULL;
        inserts_refused++;
      end else begin
        shadow_key[shadow_used[NODE_AW-1:0]] = k;
        shadow_next[shadow_used[NODE_AW-1:0]] = shadow_head[b[BKT_AW-1:0]];
        shadow_head[b[BKT_AW-1:0]] = LINK_W'(shadow_used);
        shadow_used++;
        stored_keys.push_back(k);
        inserts_taken++;
      end
    end else begin
      cur = shadow_head[b[BKT_AW-1:0]];
      steps = 0;
      while (cur < NODES && steps < NODES && !ans.found) begin
        if (shadow_key[cur[NODE_AW-1:0]] == k) begin
          ans.found = 1'b1;
        end else begin
          cur = shadow_next[cur[NODE_AW-1:0]];
          steps++;
        end
      end
      if (ans.found) begin
        query_hits++;
      end else begin
        query_misses++;
      end
    end
    return ans;
  endfunction

  task automatic send_request(op_t op, logic signed [KEY_W-1:0] k, logic pinned,
                              logic pin_found, logic pin_status);
    answer_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op;
    in_ch.key <= k;
    @(negedge clk);
    while (!in_ch.ready) begin
      @(negedge clk);
    end
    want = hash_set_apply(op, k);
    if (pinned) begin
      want.found = pin_found;
      want.status = pin_status;
    end
    expected_answers.push_back(want);
    @(posedge clk);
  endtask

  task automatic run_script(logic stage);
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].after_fill == stage) begin
        send_request(SCRIPT[i].op, SCRIPT[i].key, SCRIPT[i].pinned, SCRIPT[i].found,
                     SCRIPT[i].status);
      end
    end
  endtask

  // Hot keys pile up in three buckets so that queries walk long chains.
  task automatic run_random(int count);
    op_t                     op;
    logic signed [KEY_W-1:0] k;
    int                      pick;
    repeat (count) begin
      if ($urandom_range(99) < 55) begin
        op = OP_INSERT;
      end else begin
        op = OP_QUERY;
      end
      pick = $urandom_range(99);
      k = $urandom;
      if (op == OP_QUERY && pick < 50 && stored_keys.size() != 0) begin
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (pick >= 65) begin
        k[BKT_AW-1:0] = BKT_AW'($urandom_range(2) * 511);
      end
      send_request(op, k, 1'b0, 1'b0, ST_DONE);
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_answers.size() == 0) begin
        log_mismatch($sformatf("result word with nothing outstanding: found=%b status=%b",
                               out_ch.found, out_ch.status));
      end else begin
        want = expected_answers.pop_front();
        if (out_ch.found !== want.found) begin
          log_mismatch($sformatf("%s key %0d: found=%b, expected %b", want.op.name(),
                                 want.key, out_ch.found, want.found));
        end
        if (out_ch.status !== want.status) begin
          log_mismatch($sformatf("%s key %0d: status=%b, expected %b", want.op.name(),
                                 want.key, out_ch.status, want.status));
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("chained_hash_set regression: fail");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= OP_INSERT;
    in_ch.key <= '0;
    mismatches = 0;
    inserts_taken = 0;
    inserts_refused = 0;
    query_hits = 0;
    query_misses = 0;
    shadow_used = 0;
    foreach (shadow_head[i]) begin
      shadow_head[i] = EMPTY_LINK;
    end
    send_idle_pct = 35;
    recv_idle_pct = 62;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_script(1'b0);
    run_random(170);
    send_idle_pct = 62;
    recv_idle_pct = 35;
    run_random(170);
    while (shadow_used < NODES) begin
      send_request(OP_INSERT, $urandom, 1'b0, 1'b0, ST_DONE);
    end
    run_script(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(160);
    in_ch.valid <= 1'b0;

    while (expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (64) @(posedge clk);

    $display("Covered %0d accepted and %0d refused inserts, %0d queries (%0d hits).",
             inserts_taken, inserts_refused, query_hits + query_misses, query_hits);
    $display("Node store filled to %0d of %0d entries; %0d mismatches.", shadow_used, NODES,
             mismatches);
    if (mismatches == 0) begin
      $display("chained_hash_set regression: pass");
    end else begin
      $display("chained_hash_set regression: fail");
    end
    $finish;
  end

endmodule
